@@ rtl/complex_sample_agc_macros.svh @@
// Assertion macros for the complex sample AGC.
// Needs a clock and an active-low reset in scope of the user.
`ifndef COMPLEX_SAMPLE_AGC_MACROS_SVH
`define COMPLEX_SAMPLE_AGC_MACROS_SVH

// same-cycle implication
`define CSA_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define CSA_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

@@ rtl/csa_pkg.sv @@
// Shared types and constants for the complex sample AGC.
// No dependencies.
`timescale 1ns / 1ps
package csa_pkg;

  localparam logic [31:0] GAIN_ONE = 32'd4194304;
  localparam logic [31:0] GAIN_MIN = 32'd4;
  localparam logic [31:0] GAIN_MAX = 32'd4194304000;
  localparam int SQRT_STEPS = 16;
  // floor(x / 25) = (x * DIV25_MUL) >> DIV25_SHIFT for any 31-bit x
  localparam logic [31:0] DIV25_MUL = 32'd2748779070;
  localparam int DIV25_SHIFT = 36;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ADAPT_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_THR = 2'd2;

  typedef struct packed {
    logic signed [15:0] in_re;
    logic signed [15:0] in_im;
    logic               block_end;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] out_re;
    logic signed [15:0] out_im;
    logic [31:0]        gain_now;
    logic               block_end_out;
  } out_beat_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_SQRT, OP_DIFF, OP_DMUL, OP_DDIV, OP_LEVEL, OP_ERR,
    OP_MLO, OP_MHI, OP_UPD_DEC, OP_UPD_ACT, OP_SRE, OP_SIM, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] idx;
  } cmd_t;

  typedef struct packed {
    logic silent;
  } stat_t;

endpackage

@@ rtl/csa_datapath.sv @@
// AGC datapath: sqrt, gain update, divide by 100 and output scaling.
// Uses csa_pkg; driven by csa_ctrl commands.
`timescale 1ns / 1ps
module csa_datapath
  import csa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  in_beat_t             in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output out_beat_t            out_data
);

  logic [31:0]        rate_r;
  logic [15:0]        tgt_r;
  logic [15:0]        thr_r;
  logic [31:0]        gain_r;
  logic signed [15:0] re_r, im_r;
  logic               be_r;
  logic [31:0]        v_r, res_r;
  logic [33:0]        a_r;
  logic               neg_r;
  logic [50:0]        s_r;
  logic [34:0]        step_r;
  logic [32:0]        num_r;
  logic signed [15:0] ore_r, oim_r;
  out_beat_t          out_r;

  logic [31:0]        sq_re, sq_im, sumsq, bitv, trial;
  logic [48:0]        level_full;
  logic signed [35:0] err;
  logic signed [32:0] dgain;
  logic [63:0]        dprod;
  logic [62:0]        dq_prod;
  logic [34:0]        amt;
  logic signed [36:0] gx;
  logic [31:0]        gclamp;

  function automatic logic signed [15:0] scale_sat(logic signed [15:0] x, logic [31:0] g);
    logic [15:0] m;
    logic [47:0] p;
    logic [26:0] r;
    m = x[15] ? 16'(-x) : 16'(x);
    p = m * g;
    r = 27'((49'(p) + 49'(2097152)) >> 22);
    if (!x[15]) begin
      scale_sat = (r > 27'd32767) ? 16'sd32767 : 16'(r);
    end else begin
      scale_sat = (r > 27'd32768) ? -16'sd32768 : 16'(-r);
    end
  endfunction

  assign sq_re   = 32'(in_data.in_re * in_data.in_re);
  assign sq_im   = 32'(in_data.in_im * in_data.in_im);
  assign sumsq   = sq_re + sq_im;
  assign bitv    = 32'(1) << {cmd.idx, 1'b0};
  assign trial   = res_r + bitv;
  assign level_full = 49'(res_r[15:0] * gain_r) + 49'(16384);
  assign err     = $signed({13'b0, tgt_r, 7'b0}) - $signed({2'b0, a_r});
  assign dgain   = $signed({1'b0, GAIN_ONE}) - $signed({1'b0, gain_r});
  assign dprod   = a_r[31:0] * rate_r;
  assign dq_prod = num_r[32:2] * DIV25_MUL;
  assign amt     = (cmd.op == OP_UPD_DEC) ? {2'b0, num_r} : step_r;
  assign gx      = neg_r ? $signed({5'b0, gain_r}) - $signed({2'b0, amt})
                         : $signed({5'b0, gain_r}) + $signed({2'b0, amt});

  always_comb begin
    if (gx < $signed({5'b0, GAIN_MIN})) begin
      gclamp = GAIN_MIN;
    end else if (gx > $signed({5'b0, GAIN_MAX})) begin
      gclamp = GAIN_MAX;
    end else begin
      gclamp = gx[31:0];
    end
  end

  assign stat.silent = res_r[15:0] < thr_r;
  assign out_data    = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= 32'd42950;
      tgt_r  <= 16'd32768;
      thr_r  <= 16'd3;
      gain_r <= GAIN_ONE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ADAPT_RATE:  rate_r <= cfg_data;
          REG_TARGET:      tgt_r  <= cfg_data[15:0];
          REG_SILENCE_THR: thr_r  <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_UPD_DEC || cmd.op == OP_UPD_ACT) begin
        gain_r <= gclamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        re_r  <= in_data.in_re;
        im_r  <= in_data.in_im;
        be_r  <= in_data.block_end;
        v_r   <= sumsq;
        res_r <= '0;
      end
      OP_SQRT: begin
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bitv;
        end else begin
          res_r <= res_r >> 1;
        end
      end
      OP_DIFF: begin
        neg_r <= dgain[32];
        a_r   <= 34'(dgain[32] ? -dgain : dgain);
      end
      OP_DMUL: num_r <= {1'b0, dprod[63:32]} + 33'd50;
      // n / 100 as (n / 4) / 25
      OP_DDIV: num_r <= 33'(dq_prod >> DIV25_SHIFT);
      OP_LEVEL: a_r <= level_full[48:15];
      OP_ERR: begin
        neg_r <= err[35];
        a_r   <= 34'(err[35] ? -err : err);
      end
      OP_MLO: s_r <= 51'(a_r * rate_r[15:0]) + 51'(64'h8000_0000);
      OP_MHI: step_r <= 35'((51'(a_r * rate_r[31:16]) + (s_r >> 16)) >> 16);
      OP_SRE: ore_r <= scale_sat(re_r, gain_r);
      OP_SIM: oim_r <= scale_sat(im_r, gain_r);
      OP_OUT: out_r <= '{out_re: ore_r, out_im: oim_r, gain_now: gain_r,
                         block_end_out: be_r};
      default: ;
    endcase
  end

endmodule

@@ rtl/csa_ctrl.sv @@
// AGC sequencer: steps the datapath and owns both handshakes.
// Uses csa_pkg.
`timescale 1ns / 1ps
module csa_ctrl
  import csa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_CHK, S_DIFF, S_DMUL, S_DDIV, S_LEVEL, S_ERR,
    S_MLO, S_MHI, S_UPD_DEC, S_UPD_ACT, S_SRE, S_SIM, S_OUT
  } state_t;

  state_t     state_r;
  logic [3:0] cnt_r;
  logic       out_valid_r;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.idx = cnt_r;
    unique case (state_r)
      S_IDLE:    cmd.op = in_valid ? OP_LOAD : OP_NOP;
      S_SQRT:    cmd.op = OP_SQRT;
      S_CHK:     cmd.op = OP_NOP;
      S_DIFF:    cmd.op = OP_DIFF;
      S_DMUL:    cmd.op = OP_DMUL;
      S_DDIV:    cmd.op = OP_DDIV;
      S_LEVEL:   cmd.op = OP_LEVEL;
      S_ERR:     cmd.op = OP_ERR;
      S_MLO:     cmd.op = OP_MLO;
      S_MHI:     cmd.op = OP_MHI;
      S_UPD_DEC: cmd.op = OP_UPD_DEC;
      S_UPD_ACT: cmd.op = OP_UPD_ACT;
      S_SRE:     cmd.op = OP_SRE;
      S_SIM:     cmd.op = OP_SIM;
      S_OUT:     cmd.op = out_free ? OP_OUT : OP_NOP;
      default:   cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_SQRT;
            cnt_r   <= 4'(SQRT_STEPS - 1);
          end
        end
        S_SQRT: begin
          if (cnt_r == '0) begin
            state_r <= S_CHK;
          end else begin
            cnt_r <= cnt_r - 4'd1;
          end
        end
        S_CHK:     state_r <= stat.silent ? S_DIFF : S_LEVEL;
        S_DIFF:    state_r <= S_DMUL;
        S_DMUL:    state_r <= S_DDIV;
        S_DDIV:    state_r <= S_UPD_DEC;
        S_LEVEL:   state_r <= S_ERR;
        S_ERR:     state_r <= S_MLO;
        S_MLO:     state_r <= S_MHI;
        S_MHI:     state_r <= S_UPD_ACT;
        S_UPD_DEC: state_r <= S_SRE;
        S_UPD_ACT: state_r <= S_SRE;
        S_SRE:     state_r <= S_SIM;
        S_SIM:     state_r <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/complex_sample_agc.sv @@
// Complex sample AGC top. One sample in flight; from accept to out_valid an active sample
// runs 16 sqrt steps, the silence check, 5 gain update steps, 2 scaling steps and the output
// load, and a silent one runs 4 decay steps in place of the 5 gain update steps.
// The next sample is taken the cycle after the output register loads, and that load waits
// while out_valid holds.
// Synchronous active-low reset: gain 1.0, registers at defaults, both channels empty.
`timescale 1ns / 1ps
`include "complex_sample_agc_macros.svh"
module complex_sample_agc
  import csa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_beat_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_fire;
  logic  gain_ok;

  csa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  csa_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

  assign in_fire = in_valid && in_ready;
  assign gain_ok = out_data.gain_now >= GAIN_MIN && out_data.gain_now <= GAIN_MAX;

  `CSA_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_fire, !in_ready, "ready after input beat")
  `CSA_ASSERT_NOW(a_gain_range, clk, rst_n, out_valid, gain_ok, "gain out of range")
  `CSA_ASSERT_NOW(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(!in_ready), "stray result")

endmodule

@@ verif/complex_sample_agc_tb.sv @@
// Self-checking testbench for complex_sample_agc: drives I/Q sample beats, predicts
// gain-scaled results and the gain trajectory in fixed point, compares each output beat.
// Depends on csa_pkg and the complex_sample_agc RTL.
`timescale 1ns / 1ps
module complex_sample_agc_tb;
  import csa_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  complex_sample_agc dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [31:0] rate_q32, gain_q22;
  logic [15:0] target_q15, thresh_q15;
  out_beat_t agc_expected[$];
  int errors = 0;
  int n_sent = 0, n_checked = 0, n_silent = 0, n_clamped = 0;
  int sink_idle_pct = 35;
  bit sink_hold = 1'b0;
  int quiet_cycles = 0;

  function automatic logic [15:0] isqrt(input logic [31:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= 64'(v)) root = trial;
    end
    return root[15:0];
  endfunction

  function automatic logic signed [15:0] scale_sat(input logic signed [15:0] x,
                                                   input logic [31:0] g);
    longint m, r;
    m = (x < 0) ? -longint'(x) : longint'(x);
    r = (m * longint'(g) + (64'sd1 << 21)) >>> 22;
    if (x < 0) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic out_beat_t agc_predict(input in_beat_t s);
    out_beat_t o;
    logic [31:0] sumsq;
    longint mag, g, d, ad, q, level, err, ae, step;
    logic [127:0] p, den;
    sumsq = 32'(longint'(s.in_re) * s.in_re + longint'(s.in_im) * s.in_im);
    mag = isqrt(sumsq);
    g = gain_q22;
    if (mag < thresh_q15) begin
      n_silent++;
      d = longint'(GAIN_ONE) - g;
      ad = (d < 0) ? -d : d;
      p = 128'(ad) * rate_q32;
      den = 128'd100 << 32;
      q = longint'(p / den);
      if (p % den >= den / 2) q++;
      g = (d < 0) ? g - q : g + q;
    end else begin
      level = (mag * g + (64'sd1 << 14)) >>> 15;
      err = (longint'(target_q15) <<< 7) - level;
      ae = (err < 0) ? -err : err;
      step = longint'((128'(ae) * rate_q32 + (128'd1 << 31)) >> 32);
      g = (err < 0) ? g - step : g + step;
    end
    if (g < longint'(GAIN_MIN)) begin g = GAIN_MIN; n_clamped++; end
    if (g > longint'(GAIN_MAX)) begin g = GAIN_MAX; n_clamped++; end
    gain_q22 = 32'(g);
    o.out_re = scale_sat(s.in_re, gain_q22);
    o.out_im = scale_sat(s.in_im, gain_q22);
    o.gain_now = gain_q22;
    o.block_end_out = s.block_end;
    return o;
  endfunction

  // result checker and sink pacing
  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (agc_expected.size() == 0) begin
        $error("unexpected beat %h", out_data);
        errors++;
      end else begin
        e = agc_expected.pop_front();
        n_checked++;
        if (out_data.out_re !== e.out_re) begin
          $error("out_re exp %0d got %0d", e.out_re, out_data.out_re); errors++;
        end
        if (out_data.out_im !== e.out_im) begin
          $error("out_im exp %0d got %0d", e.out_im, out_data.out_im); errors++;
        end
        if (out_data.gain_now !== e.gain_now) begin
          $error("gain_now exp %0d got %0d", e.gain_now, out_data.gain_now); errors++;
        end
        if (out_data.block_end_out !== e.block_end_out) begin
          $error("block_end_out exp %0b got %0b", e.block_end_out, out_data.block_end_out);
          errors++;
        end
      end
    end
    out_ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  int src_idle_pct = 35;

  // valid stays up after the beat until the next idle cycle, next beat or drain
  task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                             input logic be);
    in_beat_t s;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    s.in_re = re;
    s.in_im = im;
    s.block_end = be;
    in_valid <= 1'b1;
    in_data <= s;
    agc_expected.push_back(agc_predict(s));
    n_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (agc_expected.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ADAPT_RATE) rate_q32 = val;
    else if (idx == REG_TARGET) target_q15 = val[15:0];
    else if (idx == REG_SILENCE_THR) thresh_q15 = val[15:0];
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_sample(16'sh7fff, 16'sh7fff, 1'b0);
    send_sample(-16'sd32768, -16'sd32768, 1'b1);
    send_sample(-16'sd32768, 16'sh7fff, 1'b0);
    send_sample(16'sd0, 16'sd0, 1'b1);
    send_sample(16'sd1, 16'sd1, 1'b0);
    send_sample(16'sd2, -16'sd1, 1'b0);
    send_sample(16'sh5555, -16'sh2aab, 1'b1);
    drain();
    write_reg(REG_SILENCE_THR, 32'd0);
    write_reg(REG_ADAPT_RATE, 32'hffff_ffff);
    send_sample(16'sd0, 16'sd0, 1'b0);
    send_sample(16'sd1, 16'sd0, 1'b0);
    send_sample(16'sh7fff, 16'sd0, 1'b1);
    send_sample(16'sd10, 16'sd10, 1'b0);
    drain();
    write_reg(REG_TARGET, 32'hffff_ffff);
    write_reg(REG_SILENCE_THR, 32'hffff_0000 | 16'hffff);
    send_sample(16'sh7fff, -16'sd32768, 1'b0);
    send_sample(16'sd100, 16'sd50, 1'b1);
    drain();
    write_reg(REG_TARGET, 32'd0);
    write_reg(REG_SILENCE_THR, 32'd0);
    repeat (4) send_sample(16'sh4000, 16'sh4000, 1'b0);
    drain();
    write_reg(REG_ADAPT_RATE, 32'd0);
    write_reg(REG_TARGET, 32'd32768);
    write_reg(REG_SILENCE_THR, 32'd3);
    send_sample(16'sh1234, 16'sh4321, 1'b0);
    drain();
  endtask

  task automatic random_phase(input int count, input logic [31:0] rate,
                              input logic [15:0] tgt, input logic [15:0] thr);
    int amp;
    logic signed [15:0] re, im;
    write_reg(REG_ADAPT_RATE, rate);
    write_reg(REG_TARGET, 32'(tgt));
    write_reg(REG_SILENCE_THR, 32'(thr));
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: amp = 32767;
        1: amp = 2047;
        2: amp = 15;
        default: amp = $urandom_range(32767);
      endcase
      re = 16'($signed($urandom_range(2 * amp)) - amp);
      im = 16'($signed($urandom_range(2 * amp)) - amp);
      if ($urandom_range(19) == 0) re = 16'($urandom);
      send_sample(re, im, $urandom_range(7) == 0);
    end
    drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        sink_hold = 1'b1;
        repeat (400) @(posedge clk);
        sink_hold = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_sample(16'($urandom), 16'($urandom), 1'b0);
    join
    drain();
  endtask

  task automatic test_no_idle();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    random_phase(250, 32'd42950, 16'd32768, 16'd3);
    src_idle_pct = 35;
    sink_idle_pct = 35;
  endtask

  initial begin
    rate_q32 = 32'd42950;
    target_q15 = 16'd32768;
    thresh_q15 = 16'd3;
    gain_q22 = GAIN_ONE;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    random_phase(300, 32'd42950, 16'd32768, 16'd3);
    random_phase(250, 32'h0100_0000, 16'd8000, 16'd200);
    test_backpressure();
    test_no_idle();
    random_phase(250, 32'hffff_ffff, 16'hffff, 16'd0);
    random_phase(250, 32'($urandom), 16'($urandom), 16'($urandom_range(3000)));
    $display("Sent %0d samples, checked %0d results; %0d silent, %0d clamped.",
             n_sent, n_checked, n_silent, n_clamped);
    $display("Phases: extreme configs, long sink stall, back-to-back traffic.");
    if (errors == 0 && agc_expected.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/csa_pkg.sv
rtl/csa_datapath.sv
rtl/csa_ctrl.sv
rtl/complex_sample_agc.sv
verif/complex_sample_agc_tb.sv
